// ===== sv/thg_pkg.sv =====
package thg_pkg;

    // Key length in bits and number of hash rows
    localparam int KEY_LEN    = 64;
    localparam int PA_LEN     = 32;

    // Field and register widths
    localparam int HASH_W     = 32;
    localparam int ROWS       = (PA_LEN > HASH_W) ? HASH_W : PA_LEN;
    localparam int TOP_ROW_W  = 64;
    localparam int LEFT_COL_W = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;

    // Bit counter saturates at KEY_LEN, so it must hold KEY_LEN itself
    localparam int IDX_W      = $clog2(KEY_LEN + 1);
    localparam int ROW_SEL_W  = $clog2(TOP_ROW_W);

    // Request queue between front and back
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_ROW,
        CFG_LEFT_COL
    } thg_cfg_reg_t;

    // One classified key bit as it travels from front to back
    typedef struct packed {
        logic key_bit;   // key bit value
        logic last;      // closes the round, a result follows
        logic first;     // first bit of the round: reload the column
        logic take;      // bit lies inside KEY_LEN and is applied
        logic top;       // top_row bit entering the column on top
        logic overrun;   // round has seen bits beyond KEY_LEN so far
    } thg_op_t;

endpackage

// ===== sv/toeplitz_hash_gf2_unit.sv =====
// Toeplitz hash over GF(2) for privacy amplification. Key bits enter one per
// request, bit 0 first, with last_bit marking the final bit of a key; the
// request carrying last_bit yields one result, hash_value (bit j = parity of
// matrix row j) and overrun (bits beyond KEY_LEN arrived and were dropped).
// The block takes one key bit per cycle while in_ready is high; the back end
// shifts the column and XORs it in for each popped bit. With nothing queued,
// a last bit goes into the request queue, then into the result register on
// out_valid. A two-entry request queue separates the input from the result
// register, so in_ready drops only while a finished hash waits on out_ready
// and two more requests are queued behind it. The user must write top_row and
// left_col through the cfg port between keys; the block does not enforce it.
module toeplitz_hash_gf2_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [thg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [thg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            key_bit,
    input  logic                            last_bit,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [thg_pkg::HASH_W-1:0]      hash_value,
    output logic                            overrun
);
    import thg_pkg::*;

    logic [TOP_ROW_W-1:0]  top_row_reg;
    logic [LEFT_COL_W-1:0] left_col_reg;
    logic                  q_full;
    logic                  q_push;
    thg_op_t               q_push_op;
    logic                  q_pop;
    logic                  q_head_valid;
    thg_op_t               q_head_op;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_row_reg  <= '0;
            left_col_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (thg_cfg_reg_t'(cfg_index))
                CFG_TOP_ROW:  top_row_reg  <= TOP_ROW_W'(cfg_data);
                CFG_LEFT_COL: left_col_reg <= LEFT_COL_W'(cfg_data);
                default: ;
            endcase
        end
    end

    thg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .key_bit  (key_bit),
        .last_bit (last_bit),
        .top_row  (top_row_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_push_op)
    );

    thg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_push_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_op    (q_head_op)
    );

    thg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .left_col   (left_col_reg),
        .head_valid (q_head_valid),
        .head_op    (q_head_op),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value),
        .overrun    (overrun)
    );

endmodule

// ===== sv/thg_front.sv =====
module thg_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             key_bit,
    input  logic                             last_bit,
    input  logic [thg_pkg::TOP_ROW_W-1:0]    top_row,
    input  logic                             q_full,
    output logic                             q_push,
    output thg_pkg::thg_op_t                 q_op
);
    import thg_pkg::*;

    logic [IDX_W-1:0] bit_index_reg;
    logic [IDX_W-1:0] bit_index_next;
    logic             overrun_reg;
    logic             overrun_next;
    logic             take;
    logic             accept;

    // Take a request whenever the queue has room
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;

    // Classify the incoming bit against the round position
    assign take = (bit_index_reg < IDX_W'(KEY_LEN));

    always_comb
    begin
        q_op.key_bit = key_bit;
        q_op.last    = last_bit;
        q_op.first   = (bit_index_reg == '0);
        q_op.take    = take;
        q_op.top     = top_row[ROW_SEL_W'(bit_index_reg)];
        q_op.overrun = overrun_reg || !take;
    end

    // Advance the position, saturating at KEY_LEN; clear at end of round
    always_comb
    begin
        bit_index_next = bit_index_reg;
        overrun_next   = overrun_reg;
        if (accept)
        begin
            if (last_bit)
            begin
                bit_index_next = '0;
                overrun_next   = 1'b0;
            end
            else
            begin
                if (take)
                begin
                    bit_index_next = bit_index_reg + IDX_W'(1);
                end
                overrun_next = overrun_reg || !take;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_index_reg <= '0;
            overrun_reg   <= 1'b0;
        end
        else
        begin
            bit_index_reg <= bit_index_next;
            overrun_reg   <= overrun_next;
        end
    end

endmodule

// ===== sv/thg_queue.sv =====
module thg_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  thg_pkg::thg_op_t     push_op,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output thg_pkg::thg_op_t     head_op
);
    import thg_pkg::*;

    thg_op_t              slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Hold request payloads
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== sv/thg_back.sv =====
module thg_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [thg_pkg::LEFT_COL_W-1:0]   left_col,
    input  logic                             head_valid,
    input  thg_pkg::thg_op_t                 head_op,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [thg_pkg::HASH_W-1:0]       hash_value,
    output logic                             overrun
);
    import thg_pkg::*;

    logic [ROWS-1:0]    acc_reg;
    logic [ROWS-1:0]    acc_next;
    logic [ROWS-1:0]    column_reg;
    logic [ROWS-1:0]    column_next;
    logic [ROWS-1:0]    column_step;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [HASH_W-1:0]  hash_reg;
    logic               overrun_reg;

    // Pop freely unless a result must land in an output slot that is occupied and stalled
    assign pop = head_valid && (!head_op.last || !out_valid_reg || out_ready);

    // New column: reload from left_col on the first bit, else shift down a row
    always_comb
    begin
        if (head_op.first)
        begin
            column_step = ROWS'({left_col[LEFT_COL_W-1:1], head_op.top});
        end
        else
        begin
            column_step = ROWS'({column_reg, head_op.top});
        end
    end

    // Fold the column into the accumulator; clear at end of round
    always_comb
    begin
        acc_next    = acc_reg;
        column_next = column_reg;
        if (pop && head_op.take)
        begin
            column_next = column_step;
            if (head_op.key_bit)
            begin
                acc_next = acc_reg ^ column_step;
            end
        end
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || (pop && head_op.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            column_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop && head_op.last)
            begin
                acc_reg    <= '0;
                column_reg <= '0;
            end
            else
            begin
                acc_reg    <= acc_next;
                column_reg <= column_next;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (pop && head_op.last)
        begin
            hash_reg    <= HASH_W'(acc_next);
            overrun_reg <= head_op.overrun;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;
    assign overrun    = overrun_reg;

endmodule

// ===== sv/thg_checker.sv =====
module thg_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            last_bit,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [thg_pkg::HASH_W-1:0]      hash_value,
    input  logic                            overrun
);
    import thg_pkg::*;

    logic [2:0] pending_reg;
    logic       last_in;
    logic       res_out;

    assign last_in = in_valid && in_ready && last_bit;
    assign res_out = out_valid && out_ready;

    // Count keys closed at the input whose hash is not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (last_in && !res_out)
        begin
            pending_reg <= pending_reg + 3'd1;
        end
        else if (res_out && !last_in)
        begin
            pending_reg <= pending_reg - 3'd1;
        end
    end

    // Stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hash_value) && $stable(overrun))
        else $error("result changed while stalled");

    // No result without a closed key behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without a last key bit");

    // Queue plus output register bound the backlog of closed keys
    a_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("too many undelivered keys");

    // Input is never refused while the result side is empty
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && $past(!out_valid) && $past(!out_valid, 2) |-> in_ready)
        else $error("input stalled with no pending result");

endmodule

bind toeplitz_hash_gf2_unit thg_checker u_thg_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import thg_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_REQUESTS = 250;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  key_bit;
    logic                  last_bit;
    logic                  out_valid;
    logic                  out_ready;
    logic [HASH_W-1:0]     hash_value;
    logic                  overrun;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit rx_hold_req = 1'b0;

    // Tracks the Toeplitz matrix product bit by bit and queues finished hashes
    class hash_scoreboard;
        logic [TOP_ROW_W-1:0]  row_bits;
        logic [LEFT_COL_W-1:0] col_bits;
        logic [HASH_W-1:0]     acc;
        logic [HASH_W-1:0]     column;
        logic [6:0]            bits_taken;
        logic                  extra_seen;
        logic [HASH_W-1:0]     hash_q[$];
        logic                  overrun_q[$];
        int                    errors;

        function new();
            row_bits = '0;
            col_bits = '0;
            errors   = 0;
            clear_round();
        endfunction

        function void clear_round();
            acc        = '0;
            column     = '0;
            bits_taken = '0;
            extra_seen = 1'b0;
        endfunction

        function void set_matrix(logic [TOP_ROW_W-1:0] row, logic [LEFT_COL_W-1:0] col);
            row_bits = row;
            col_bits = col;
        endfunction

        function int pending();
            return hash_q.size();
        endfunction

        // Apply one accepted key bit; a closing bit queues the hash
        function void note_request(logic kb, logic closing);
            logic top;
            logic [HASH_W-1:0] row_mask;
            row_mask = (ROWS >= HASH_W) ? '1 : ((HASH_W'(1) << ROWS) - 1'b1);
            if (bits_taken >= KEY_LEN) begin
                extra_seen = 1'b1;
            end
            else begin
                top = row_bits[bits_taken[5:0]];
                if (bits_taken == 0)
                    column = {col_bits[HASH_W-1:1], top} & row_mask;
                else
                    column = {column[HASH_W-2:0], top} & row_mask;
                if (kb)
                    acc ^= column;
                bits_taken = bits_taken + 1'b1;
            end
            if (closing) begin
                hash_q.push_back(acc & row_mask);
                overrun_q.push_back(extra_seen);
                clear_round();
            end
        endfunction

        function void check_result(logic [HASH_W-1:0] hash, logic ovr);
            logic [HASH_W-1:0] want_hash;
            logic              want_ovr;
            if (hash_q.size() == 0) begin
                $display("%0t: unexpected result hash %h overrun %b", $time, hash, ovr);
                errors++;
                return;
            end
            want_hash = hash_q.pop_front();
            want_ovr  = overrun_q.pop_front();
            if (hash !== want_hash) begin
                $display("%0t: hash_value mismatch: expected %h actual %h",
                         $time, want_hash, hash);
                errors++;
            end
            if (ovr !== want_ovr) begin
                $display("%0t: overrun mismatch: expected %b actual %b",
                         $time, want_ovr, ovr);
                errors++;
            end
        endfunction
    endclass

    hash_scoreboard sb = new();

    toeplitz_hash_gf2_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .key_bit    (key_bit),
        .last_bit   (last_bit),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value),
        .overrun    (overrun)
    );

    always #10 clk = ~clk;

    // Watch both handshakes at each edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_result(hash_value, overrun);
            if (in_valid && in_ready)
                sb.note_request(key_bit, last_bit);
        end
    end

    // Drive out_ready; hold it low for a long stretch when asked
    initial begin
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one key bit and hold it until the request is taken
    task automatic send_bit(logic kb, logic closing);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key_bit  <= kb;
        last_bit <= closing;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_round(logic [127:0] bits, int len);
        for (int i = 0; i < len; i++)
            send_bit(bits[i], i == len - 1);
    endtask

    // Drop valid, wait for every hash, then let the pipeline drain
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_matrix(logic [TOP_ROW_W-1:0] row, logic [LEFT_COL_W-1:0] col);
        sb.set_matrix(row, col);
        cfg_write <= 1'b1;
        cfg_index <= CFG_TOP_ROW;
        cfg_data  <= row;
        @(posedge clk);
        cfg_index <= CFG_LEFT_COL;
        cfg_data  <= CFG_DATA_W'(col);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Random keys: mostly in range, some exactly full, some past KEY_LEN
    task automatic random_rounds(int budget);
        int           sent;
        int           len;
        int           pick;
        logic [127:0] bits;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(15);
            if (pick < 4)
                len = $urandom_range(4, 1);
            else if (pick < 10)
                len = $urandom_range(KEY_LEN, 1);
            else if (pick < 12)
                len = KEY_LEN;
            else if (pick < 14)
                len = $urandom_range(KEY_LEN, KEY_LEN - 8);
            else
                len = $urandom_range(KEY_LEN + 8, KEY_LEN + 1);
            bits = {$urandom, $urandom, $urandom, $urandom};
            send_round(bits, len);
            sent += len;
        end
    endtask

    initial begin
        logic [TOP_ROW_W-1:0]  row;
        logic [LEFT_COL_W-1:0] col;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_TOP_ROW;
        cfg_data  = '0;
        in_valid  = 1'b0;
        key_bit   = 1'b0;
        last_bit  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full matrix, single-bit keys, short keys
        write_matrix('1, '1);
        send_round(128'h1, 1);
        send_round(128'h0, 1);
        send_round(128'hF, 4);
        send_round(128'h8, 4);
        settle();

        // Directed: empty matrix gives a zero hash
        write_matrix('0, '0);
        send_round(128'h3, 2);
        send_round(128'h1, 1);
        settle();

        // Directed: sparse pattern checks the column shift
        write_matrix(64'h8000_0000_0000_0001, 32'h8000_0001);
        send_round(128'hAD, 8);
        send_round(128'h4, 3);
        settle();

        // Random phases: receiver-heavy idling, sender-heavy, then none
        for (int ph = 0; ph < 6; ph++) begin
            tx_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 86 : 0;
            rx_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 37 : 0;
            row = {$urandom, $urandom};
            col = $urandom;
            if (ph == 1) begin
                row = '1;
                col = '0;
            end
            if (ph == 3) begin
                row = '0;
                col = '1;
            end
            write_matrix(row, col);
            if (ph == 4)
                rx_hold_req = 1'b1;
            random_rounds(PHASE_REQUESTS);
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/thg_pkg.sv
sv/thg_front.sv
sv/thg_queue.sv
sv/thg_back.sv
sv/toeplitz_hash_gf2_unit.sv
sv/thg_checker.sv
tb/tb_top.sv
